[sv/plane_plane_intersection_assert.svh]
// Assertion macros for the plane intersection block
`ifndef PLANE_PLANE_INTERSECTION_ASSERT_SVH
`define PLANE_PLANE_INTERSECTION_ASSERT_SVH

// clocked check, quiet while reset is high
`define PPI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds across reset
`define PPI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/ppi_pkg.sv]
// Shared widths, constants and types for the plane intersection block
`default_nettype none
package ppi_pkg;
  localparam int NRM_W = 16;
  localparam int OFF_W = 32;
  localparam int DIR_W = 34;
  localparam int MSQ_W = 40;
  localparam int DEN_W = 64;
  localparam int CRS_W = 49;
  localparam int NUM_W = 81;
  localparam int QB_W = 33;
  localparam int DIV_STAGES = QB_W;
  localparam int FRONT_STAGES = 8;
  localparam int PIPE_LAT = FRONT_STAGES + DIV_STAGES + 2;
  localparam int U_DLY = PIPE_LAT - 2;
  localparam logic [MSQ_W-1:0] MIN_DIR_SQ_RST = 40'd72058;

  typedef struct packed {
    logic       keep;
    logic [2:0] neg;
    logic [2:0] ovf;
  } div_ctl_t;
endpackage
`default_nettype wire

[sv/ppi_div.sv]
// Pipelined restoring divider, one quotient bit per stage, three lanes on one divisor
`default_nettype none
module ppi_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_vld,
  input  ppi_pkg::div_ctl_t                   in_ctl,
  input  logic [ppi_pkg::DEN_W-1:0]           in_den,
  input  logic [2:0][ppi_pkg::DEN_W-1:0]      in_rem,
  input  logic [2:0][ppi_pkg::QB_W-1:0]       in_qs,
  output logic                                out_vld,
  output logic                                out_keep,
  output logic [2:0][ppi_pkg::OFF_W-1:0]      out_p
);
  import ppi_pkg::*;

  localparam logic [QB_W-1:0] LIM_POS = 33'h07FFFFFFF;
  localparam logic [QB_W-1:0] LIM_NEG = 33'h080000000;

  logic                         vld [DIV_STAGES+1];
  div_ctl_t                     ctl [DIV_STAGES+1];
  logic [DEN_W-1:0]             den [DIV_STAGES+1];
  logic [2:0][DEN_W-1:0]        rem [DIV_STAGES+1];
  logic [2:0][QB_W-1:0]         qs  [DIV_STAGES+1];

  logic [2:0][DEN_W-1:0]        rem_next [DIV_STAGES];
  logic [2:0][QB_W-1:0]         qs_next  [DIV_STAGES];
  logic [2:0][OFF_W-1:0]        p_next;

  always_comb begin
    logic [DEN_W:0] tw;
    logic [DEN_W:0] df;
    logic           ge;
    for (int k = 0; k < DIV_STAGES; k++) begin
      for (int l = 0; l < 3; l++) begin
        tw = {rem[k][l], qs[k][l][QB_W-1]};
        df = tw - {1'b0, den[k]};
        ge = tw >= {1'b0, den[k]};
        rem_next[k][l] = ge ? df[DEN_W-1:0] : tw[DEN_W-1:0];
        qs_next[k][l] = {qs[k][l][QB_W-2:0], ge};
      end
    end
  end

  always_comb begin
    logic [QB_W:0]   rs;
    logic [QB_W-1:0] rq;
    logic [QB_W-1:0] lim;
    logic [QB_W-1:0] mg;
    for (int l = 0; l < 3; l++) begin
      rs = {1'b0, qs[DIV_STAGES][l]} + {{QB_W{1'b0}}, 1'b1};
      rq = rs[QB_W:1];
      lim = ctl[DIV_STAGES].neg[l] ? LIM_NEG : LIM_POS;
      mg = (ctl[DIV_STAGES].ovf[l] || rq > lim) ? lim : rq;
      if (!ctl[DIV_STAGES].keep) begin
        p_next[l] = '0;
      end else if (ctl[DIV_STAGES].neg[l]) begin
        p_next[l] = -mg[OFF_W-1:0];
      end else begin
        p_next[l] = mg[OFF_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_STAGES; k++) vld[k] <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld[0] <= in_vld;
      for (int k = 1; k <= DIV_STAGES; k++) vld[k] <= vld[k-1];
      out_vld <= vld[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    ctl[0] <= in_ctl;
    den[0] <= in_den;
    rem[0] <= in_rem;
    qs[0] <= in_qs;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      ctl[k] <= ctl[k-1];
      den[k] <= den[k-1];
      rem[k] <= rem_next[k-1];
      qs[k] <= qs_next[k-1];
    end
    out_keep <= ctl[DIV_STAGES].keep;
    out_p <= p_next;
  end
endmodule
`default_nettype wire

[sv/plane_plane_intersection.sv]
// Intersection line of two planes: direction, nearest point, parallel flag
// Throughput: one request per cycle; busy is always low and nothing stalls.
// The pipeline has 8 front stages, a divider input stage, 33 quotient-bit stages and an output stage.
// Reset clears every stage valid and loads min_dir_sq with its default.
// The receiver cannot stall: done is a one-cycle strobe.
`default_nettype none
module plane_plane_intersection (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               cfg_we,
  input  logic [ppi_pkg::MSQ_W-1:0]          cfg_data,
  input  logic signed [ppi_pkg::NRM_W-1:0]   a_nx,
  input  logic signed [ppi_pkg::NRM_W-1:0]   a_ny,
  input  logic signed [ppi_pkg::NRM_W-1:0]   a_nz,
  input  logic signed [ppi_pkg::OFF_W-1:0]   a_off,
  input  logic signed [ppi_pkg::NRM_W-1:0]   b_nx,
  input  logic signed [ppi_pkg::NRM_W-1:0]   b_ny,
  input  logic signed [ppi_pkg::NRM_W-1:0]   b_nz,
  input  logic signed [ppi_pkg::OFF_W-1:0]   b_off,
  output logic                               done,
  output logic                               valid_res,
  output logic signed [ppi_pkg::OFF_W-1:0]   px,
  output logic signed [ppi_pkg::OFF_W-1:0]   py,
  output logic signed [ppi_pkg::OFF_W-1:0]   pz,
  output logic signed [ppi_pkg::DIR_W-1:0]   dx,
  output logic signed [ppi_pkg::DIR_W-1:0]   dy,
  output logic signed [ppi_pkg::DIR_W-1:0]   dz
);
  import ppi_pkg::*;

  localparam int LJ [3] = '{1, 2, 0};
  localparam int LK [3] = '{2, 0, 1};

  logic [MSQ_W-1:0] min_dir_sq;
  logic [FRONT_STAGES:1] v;

  logic signed [NRM_W-1:0] na1 [3], nb1 [3], na2 [3], nb2 [3], na3 [3], nb3 [3];
  logic signed [OFF_W-1:0] da1, db1, da2, db2, da3, db3, da4, db4, da5, db5;
  logic signed [2*NRM_W-1:0] pr2 [6];
  logic signed [DIR_W-1:0] ud [U_DLY][3];
  logic [DEN_W-1:0] sq4 [3];
  logic signed [NRM_W+DIR_W-1:0] cp4 [12];
  logic [DEN_W-1:0] den5, den6, den7, den8;
  logic signed [CRS_W-1:0] cr5 [6];
  logic [55:0] pl6 [6], ph6 [6];
  logic ng6 [6];
  logic keep6, keep7, keep8;
  logic signed [NUM_W-1:0] tm7 [6];
  logic signed [NUM_W-1:0] num8 [3];

  logic [31:0] umag [3];
  logic signed [CRS_W+1:0] crd [6];
  logic [OFF_W-1:0] adm [6];
  logic [CRS_W-2:0] cmag [6];
  logic tneg [6];
  div_ctl_t dctl;
  logic [2:0][DEN_W-1:0] drem;
  logic [2:0][QB_W-1:0] dqs;
  logic dv_keep;
  logic [2:0][OFF_W-1:0] dv_p;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_dir_sq <= MIN_DIR_SQ_RST;
      v <= '0;
    end else begin
      if (cfg_we) begin
        min_dir_sq <= cfg_data;
      end
      v <= {v[FRONT_STAGES-1:1], start & !busy};
    end
  end

  always_comb begin
    logic signed [DIR_W-1:0] un;
    logic signed [OFF_W:0] dn;
    logic signed [OFF_W-1:0] dv;
    logic signed [CRS_W-1:0] cv;
    logic signed [CRS_W-1:0] cn;
    for (int i = 0; i < 3; i++) begin
      un = -ud[0][i];
      umag[i] = ud[0][i][DIR_W-1] ? un[31:0] : ud[0][i][31:0];
      crd[i] = cp4[4*i] - cp4[4*i+1];
      crd[3+i] = cp4[4*i+2] - cp4[4*i+3];
    end
    for (int t = 0; t < 6; t++) begin
      dv = (t < 3) ? da5 : db5;
      dn = -{dv[OFF_W-1], dv};
      adm[t] = dv[OFF_W-1] ? dn[OFF_W-1:0] : dv;
      cv = cr5[t];
      cn = -cv;
      cmag[t] = cv[CRS_W-1] ? cn[CRS_W-2:0] : cv[CRS_W-2:0];
      tneg[t] = (!dv[OFF_W-1] && dv != '0) ^ cv[CRS_W-1];
    end
  end

  always_ff @(posedge clk) begin
    na1 <= '{a_nx, a_ny, a_nz};
    nb1 <= '{b_nx, b_ny, b_nz};
    da1 <= a_off;
    db1 <= b_off;

    for (int i = 0; i < 3; i++) begin
      pr2[2*i] <= na1[LJ[i]] * nb1[LK[i]];
      pr2[2*i+1] <= na1[LK[i]] * nb1[LJ[i]];
    end
    na2 <= na1;
    nb2 <= nb1;
    da2 <= da1;
    db2 <= db1;

    for (int i = 0; i < 3; i++) begin
      ud[0][i] <= pr2[2*i] - pr2[2*i+1];
    end
    for (int k = 1; k < U_DLY; k++) begin
      ud[k] <= ud[k-1];
    end
    na3 <= na2;
    nb3 <= nb2;
    da3 <= da2;
    db3 <= db2;

    for (int i = 0; i < 3; i++) begin
      sq4[i] <= umag[i] * umag[i];
      cp4[4*i] <= nb3[LJ[i]] * ud[0][LK[i]];
      cp4[4*i+1] <= nb3[LK[i]] * ud[0][LJ[i]];
      cp4[4*i+2] <= ud[0][LJ[i]] * na3[LK[i]];
      cp4[4*i+3] <= ud[0][LK[i]] * na3[LJ[i]];
    end
    da4 <= da3;
    db4 <= db3;

    den5 <= sq4[0] + sq4[1] + sq4[2];
    for (int t = 0; t < 6; t++) begin
      cr5[t] <= crd[t][CRS_W-1:0];
    end
    da5 <= da4;
    db5 <= db4;

    for (int t = 0; t < 6; t++) begin
      pl6[t] <= adm[t] * cmag[t][23:0];
      ph6[t] <= adm[t] * cmag[t][47:24];
      ng6[t] <= tneg[t];
    end
    keep6 <= (den5 != '0) && (den5 >= {{(DEN_W-MSQ_W){1'b0}}, min_dir_sq});
    den6 <= den5;

    for (int t = 0; t < 6; t++) begin
      tm7[t] <= ng6[t] ? -{1'b0, {ph6[t], 24'b0} + {24'b0, pl6[t]}}
                       :  {1'b0, {ph6[t], 24'b0} + {24'b0, pl6[t]}};
    end
    keep7 <= keep6;
    den7 <= den6;

    for (int i = 0; i < 3; i++) begin
      num8[i] <= tm7[i] + tm7[3+i];
    end
    keep8 <= keep7;
    den8 <= den7;
  end

  always_comb begin
    logic signed [NUM_W-1:0] nn;
    logic [NUM_W-2:0] nm;
    dctl.keep = keep8;
    for (int i = 0; i < 3; i++) begin
      nn = -num8[i];
      nm = num8[i][NUM_W-1] ? nn[NUM_W-2:0] : num8[i][NUM_W-2:0];
      dctl.neg[i] = num8[i][NUM_W-1];
      drem[i] = {2'b0, nm[NUM_W-2:18]};
      dctl.ovf[i] = drem[i] >= den8;
      dqs[i] = {nm[17:0], 15'b0};
    end
  end

  ppi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (v[FRONT_STAGES]),
    .in_ctl   (dctl),
    .in_den   (den8),
    .in_rem   (drem),
    .in_qs    (dqs),
    .out_vld  (done),
    .out_keep (dv_keep),
    .out_p    (dv_p)
  );

  assign valid_res = dv_keep;
  assign px = dv_p[0];
  assign py = dv_p[1];
  assign pz = dv_p[2];
  assign dx = ud[U_DLY-1][0];
  assign dy = ud[U_DLY-1][1];
  assign dz = ud[U_DLY-1][2];
endmodule
`default_nettype wire

[sv/ppi_chk.sv]
// Port-level checks for the plane intersection block, bound to the top level
`default_nettype none
`include "plane_plane_intersection_assert.svh"
module ppi_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic                               done,
  input logic                               valid_res,
  input logic signed [ppi_pkg::OFF_W-1:0]   px,
  input logic signed [ppi_pkg::OFF_W-1:0]   py,
  input logic signed [ppi_pkg::OFF_W-1:0]   pz,
  input logic signed [ppi_pkg::DIR_W-1:0]   dx,
  input logic signed [ppi_pkg::DIR_W-1:0]   dy,
  input logic signed [ppi_pkg::DIR_W-1:0]   dz
);
  import ppi_pkg::*;

  `PPI_ASSERT_ALWAYS(a_rst_quiet, rst |=> !done, "result strobe right after reset")
  `PPI_ASSERT(a_latency, start && !busy |-> ##PIPE_LAT done, "request lost in pipeline")
  `PPI_ASSERT(a_no_ghost, done |-> $past(start && !busy, PIPE_LAT), "result without request")
  `PPI_ASSERT(a_par_zero, done && !valid_res |-> px == 0 && py == 0 && pz == 0, "parallel point")
  `PPI_ASSERT(a_zero_dir, done && dx == 0 && dy == 0 && dz == 0 |-> !valid_res, "zero dir valid")
endmodule

bind plane_plane_intersection ppi_chk u_ppi_chk (.*);
`default_nettype wire

[dv/plane_plane_intersection_test.sv]
// Self-checking testbench for the two-plane intersection line block
module plane_plane_intersection_test;
  import ppi_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = PIPE_LAT + 10;

  typedef struct packed {
    logic signed [NRM_W-1:0] a_nx, a_ny, a_nz;
    logic signed [OFF_W-1:0] a_off;
    logic signed [NRM_W-1:0] b_nx, b_ny, b_nz;
    logic signed [OFF_W-1:0] b_off;
  } plane_pair_t;

  typedef struct packed {
    logic                    valid_res;
    logic signed [OFF_W-1:0] px, py, pz;
    logic signed [DIR_W-1:0] dx, dy, dz;
  } line_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cfg_we = 1'b0;
  logic [MSQ_W-1:0] cfg_data = '0;
  plane_pair_t req = '0;
  logic done, valid_res;
  logic signed [OFF_W-1:0] px, py, pz;
  logic signed [DIR_W-1:0] dx, dy, dz;

  plane_pair_t pair_q[$];
  line_t line_q[$];
  logic [MSQ_W-1:0] thresh = MIN_DIR_SQ_RST;
  bit steady = 0;
  int errors = 0;
  int cycles = 0;

  plane_plane_intersection u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .a_nx(req.a_nx), .a_ny(req.a_ny), .a_nz(req.a_nz), .a_off(req.a_off),
    .b_nx(req.b_nx), .b_ny(req.b_ny), .b_nz(req.b_nz), .b_off(req.b_off),
    .done(done), .valid_res(valid_res),
    .px(px), .py(py), .pz(pz), .dx(dx), .dy(dy), .dz(dz)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic signed [OFF_W-1:0] nearest_coord(
      input logic signed [159:0] num, input logic signed [159:0] den);
    logic signed [159:0] m, q, lim, r;
    logic neg;
    neg = num < 0;
    m = neg ? -num : num;
    q = ((m <<< 15) / den + 1) >>> 1;
    lim = neg ? 160'sh80000000 : 160'sh7FFFFFFF;
    if (q > lim) q = lim;
    r = neg ? -q : q;
    nearest_coord = r[OFF_W-1:0];
  endfunction

  function automatic line_t intersect_line(input plane_pair_t r,
                                           input logic [MSQ_W-1:0] thr);
    logic signed [159:0] ax, ay, az, ad, bx, by, bz, bd, ux, uy, uz, den;
    logic signed [159:0] c1x, c1y, c1z, c2x, c2y, c2z;
    line_t e;
    ax = r.a_nx; ay = r.a_ny; az = r.a_nz; ad = r.a_off;
    bx = r.b_nx; by = r.b_ny; bz = r.b_nz; bd = r.b_off;
    ux = ay * bz - az * by;
    uy = az * bx - ax * bz;
    uz = ax * by - ay * bx;
    den = ux * ux + uy * uy + uz * uz;
    e = '0;
    e.dx = ux[DIR_W-1:0];
    e.dy = uy[DIR_W-1:0];
    e.dz = uz[DIR_W-1:0];
    e.valid_res = (den != 0) && (den >= $signed({120'd0, thr}));
    if (e.valid_res) begin
      c1x = by * uz - bz * uy; c1y = bz * ux - bx * uz; c1z = bx * uy - by * ux;
      c2x = uy * az - uz * ay; c2y = uz * ax - ux * az; c2z = ux * ay - uy * ax;
      e.px = nearest_coord(-ad * c1x - bd * c2x, den);
      e.py = nearest_coord(-ad * c1y - bd * c2y, den);
      e.pz = nearest_coord(-ad * c1z - bd * c2z, den);
    end
    return e;
  endfunction

  function automatic plane_pair_t mk(int ax, int ay, int az, int ad,
                                     int bx, int by, int bz, int bd);
    plane_pair_t r;
    r.a_nx = NRM_W'(ax); r.a_ny = NRM_W'(ay); r.a_nz = NRM_W'(az); r.a_off = ad;
    r.b_nx = NRM_W'(bx); r.b_ny = NRM_W'(by); r.b_nz = NRM_W'(bz); r.b_off = bd;
    return r;
  endfunction

  function automatic int rand_off();
    return $urandom_range(1) ? int'($urandom) : $urandom_range(2097152) - 1048576;
  endfunction

  function automatic plane_pair_t rand_pair();
    plane_pair_t r;
    int sel;
    sel = $urandom_range(2);
    r = {$urandom, $urandom, $urandom, $urandom, $urandom};
    if (sel == 1) begin
      r = mk($urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
             $urandom_range(32768) - 16384, rand_off(),
             $urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
             $urandom_range(32768) - 16384, rand_off());
    end else if (sel == 2) begin
      // near-parallel pair: tiny direction, large or saturated point
      r.a_nx = NRM_W'($urandom_range(32767) - 16384);
      r.a_ny = NRM_W'($urandom_range(32767) - 16384);
      r.a_nz = NRM_W'($urandom_range(32767) - 16384);
      r.b_nx = r.a_nx + $signed(NRM_W'($urandom_range(6) - 3));
      r.b_ny = r.a_ny + $signed(NRM_W'($urandom_range(6) - 3));
      r.b_nz = r.a_nz + $signed(NRM_W'($urandom_range(6) - 3));
      r.a_off = rand_off();
      r.b_off = rand_off();
    end
    return r;
  endfunction

  task automatic write_thresh(input logic [MSQ_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    thresh = v;
  endtask

  task automatic settle();
    while (pair_q.size() || line_q.size() || start) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_random(input int n);
    repeat (n) pair_q.push_back(rand_pair());
  endtask

  task automatic add_directed();
    pair_q.push_back(mk(16384, 0, 0, 196608, 0, 16384, 0, -65536));
    pair_q.push_back(mk(-32768, -32768, -32768, -2147483648,
                        32767, 32767, 32767, 2147483647));
    pair_q.push_back(mk(-32768, 0, 0, 2147483647, 0, -32768, 0, -2147483648));
    pair_q.push_back(mk(-32768, 32767, 0, -2147483648, 32767, 0, -32768, -2147483648));
    pair_q.push_back(mk(12000, -5000, 700, 65536, 12000, -5000, 700, 1000));
    pair_q.push_back(mk(0, 0, 0, 12345, 0, 0, 0, -12345));
    pair_q.push_back(mk(0, 16384, 0, 5, 0, -16384, 0, 7));
    pair_q.push_back(mk(16384, 0, 0, 2147483647, 16384, 1, 0, -2147483648));
    pair_q.push_back(mk(16384, 0, 0, -65536, 16384, 0, 1, 65536));
    pair_q.push_back(mk(1, 0, 0, 65536, 0, 1, 0, 65536));
    pair_q.push_back(mk(268, 0, 0, 2147483647, 0, 1, 0, 2147483647));
    pair_q.push_back(mk(11585, 11585, 0, -327680, 0, 11585, 11585, 655360));
    pair_q.push_back(mk(32767, -32768, 1, 0, -1, 32767, -32768, 0));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) line_q.push_back(intersect_line(req, thresh));
      if (!(start && busy)) begin
        if (pair_q.size() > 0 && (steady || $urandom_range(99) >= 29)) begin
          req <= pair_q.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic cmp(input string nm, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      $display("%0t mismatch %s expected %0h actual %0h", $realtime, nm, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    line_t e;
    if (!rst && done) begin
      if (line_q.size() == 0) begin
        $display("%0t unexpected result", $realtime);
        errors++;
      end else begin
        e = line_q.pop_front();
        cmp("valid_res", e.valid_res, valid_res);
        cmp("px", e.px, px);
        cmp("py", e.py, py);
        cmp("pz", e.pz, pz);
        cmp("dx", e.dx, dx);
        cmp("dy", e.dy, dy);
        cmp("dz", e.dz, dz);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL plane_plane_intersection");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    add_directed();
    add_random(150);
    settle();
    write_thresh('0);
    add_directed();
    add_random(150);
    settle();
    write_thresh({MSQ_W{1'b1}});
    add_random(150);
    settle();
    write_thresh(40'd1);
    steady = 1;
    add_random(150);
    settle();
    steady = 0;
    write_thresh(MSQ_W'({$urandom_range(255), $urandom} >> $urandom_range(39)));
    add_random(100);
    settle();
    write_thresh(MIN_DIR_SQ_RST);
    add_random(100);
    settle();
    if (errors == 0) begin
      $display("PASS plane_plane_intersection");
    end else begin
      $display("FAIL plane_plane_intersection");
    end
    $finish;
  end
endmodule
